### sv/blf_pkg.sv
// Shared types and constants of the binary 3x3 lookup-table image filter.
// No dependencies; the core, the checker and the testbench import this package.
package blf_pkg;

    typedef logic [8:0] t_window;

    localparam int unsigned TABLE_WORDS = 8;
    localparam int unsigned TABLE_WORD_W = 64;
    localparam int unsigned TABLE_BITS = TABLE_WORDS * TABLE_WORD_W;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned LIT_W = 17;

    localparam t_window SLIDE_MASK = 9'h1B6;  // keeps the two left columns after a shift
    localparam t_window BG_COLUMN = 9'h049;   // one lit column
    localparam t_window TABLE_IDX_LAST = 9'h1FF;
    localparam t_window TABLE_IDX_FIRST = 9'h000;

    localparam logic [LIT_W-1:0] LIT_MAX = 17'd65536;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

endpackage

### sv/blf_in_if.sv
// Input channel of the lookup-table filter: valid/ready with one pixel transaction.
// Standalone interface, no dependencies.
interface blf_in_if;
    logic valid;
    logic ready;
    logic command;
    logic pixel_value;
    logic row_end;
    logic frame_end;

    modport source (output valid, command, pixel_value, row_end, frame_end, input ready);
    modport sink (input valid, command, pixel_value, row_end, frame_end, output ready);
endinterface

### sv/blf_out_if.sv
// Result channel of the lookup-table filter: valid/ready with one filtered pixel.
// Standalone interface, no dependencies.
interface blf_out_if;
    logic        valid;
    logic        ready;
    logic        filtered_pixel;
    logic        out_row_end;
    logic        out_frame_end;
    logic [16:0] lit_total;

    modport source (output valid, filtered_pixel, out_row_end, out_frame_end, lit_total,
                    input ready);
    modport sink (input valid, filtered_pixel, out_row_end, out_frame_end, lit_total,
                  output ready);
endinterface

### sv/blf_ram.sv
// Generic single-write, single-read RAM with registered read data (read-old on collision).
// No dependencies.
module blf_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/binary_3x3_lut_image_filter_core.sv
// Streaming binary 3x3 lookup-table filter. One transaction is accepted per clock while the
// receiver keeps up; a finished result left waiting in the output register holds off the input
// until it is taken. Each pixel reads its column from a two-bit-wide line RAM (upper and middle
// rows) prefetched for the next transaction, slides the 3x3 window and looks the window up in
// the 512-bit table; the result is registered in the cycle after acceptance, and a pixel's
// result is caused row_length+1 transactions later.
// Depends on blf_pkg, blf_in_if, blf_out_if and blf_ram.
module binary_3x3_lut_image_filter_core
    import blf_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 256,
    parameter int unsigned MAX_HEIGHT = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [TABLE_WORD_W-1:0] i_cfg_data,
    blf_in_if.sink                  i_pix,
    blf_out_if.source               o_res
);
    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned RL_W = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RC_W = $clog2(MAX_HEIGHT + 2);
    localparam logic [RL_W-1:0] WIDTH_LIMIT = RL_W'(MAX_WIDTH);
    localparam logic [RC_W-1:0] ROW_SAT = RC_W'(MAX_HEIGHT + 1);
    localparam logic [RC_W-1:0] ROW_ONE = RC_W'(1);
    localparam logic [RC_W-1:0] ROW_TWO = RC_W'(2);

    logic [TABLE_BITS-1:0] r_table;
    logic [COL_W-1:0]      r_col, n_col;
    logic [RL_W-1:0]       r_row_len, n_row_len;
    logic [RC_W-1:0]       r_row_cnt, n_row_cnt;
    t_window               r_win, n_win;
    logic                  r_bg, n_bg;
    logic [LIT_W-1:0]      r_lit, n_lit;
    logic                  r_fwd;
    logic [1:0]            r_fwd_data;
    logic                  r_out_valid;
    logic                  r_out_pix;
    logic                  r_out_row_end;
    logic                  r_out_frame_end;
    logic [LIT_W-1:0]      r_out_lit;

    logic                  accept;
    logic                  pix;
    logic [1:0]            ram_rdata;
    logic [1:0]            line_data;
    logic                  up;
    logic                  mid;
    t_window               new_col;
    t_window               win;
    logic                  emit;
    logic                  filt;
    logic [RL_W-1:0]       col_inc;
    logic                  row_last;
    logic [COL_W-1:0]      ram_raddr;

    assign i_pix.ready = !r_out_valid || o_res.ready;
    assign accept = i_pix.valid && i_pix.ready;

    assign pix = (i_pix.command == CMD_DRAIN) ? r_bg : i_pix.pixel_value;

    // bypass the RAM when the column just written is read again (one-pixel rows)
    assign line_data = r_fwd ? r_fwd_data : ram_rdata;
    assign up = (r_row_cnt >= ROW_TWO) ? line_data[1] : r_bg;
    assign mid = (r_row_cnt >= ROW_ONE) ? line_data[0] : r_bg;
    assign new_col = {2'b00, up, 2'b00, mid, 2'b00, pix};

    always_comb begin
        if (r_col == '0) begin
            win = ((r_win << 1) & SLIDE_MASK) | (r_bg ? BG_COLUMN : '0);
            n_win = (r_bg ? SLIDE_MASK : '0) | new_col;
            emit = (r_row_cnt >= ROW_TWO);
        end else begin
            win = ((r_win << 1) & SLIDE_MASK) | new_col;
            n_win = win;
            emit = (r_row_cnt >= ROW_ONE);
        end
    end

    assign filt = r_table[win];
    assign n_lit = (emit && filt && (r_lit < LIT_MAX)) ? r_lit + 1'b1 : r_lit;

    assign col_inc = RL_W'(r_col) + 1'b1;
    assign row_last = (r_row_len == '0) ? (i_pix.row_end || (col_inc >= WIDTH_LIMIT))
                                        : (col_inc >= r_row_len);

    always_comb begin
        n_col = row_last ? '0 : COL_W'(col_inc);
        n_row_len = (r_row_len == '0 && row_last) ? col_inc : r_row_len;
        n_row_cnt = (row_last && (r_row_cnt < ROW_SAT)) ? r_row_cnt + 1'b1 : r_row_cnt;
        n_bg = r_bg;
        if (i_pix.frame_end) begin
            n_col = '0;
            n_row_len = '0;
            n_row_cnt = '0;
            n_bg = r_bg ? r_table[TABLE_IDX_LAST] : r_table[TABLE_IDX_FIRST];
        end
    end

    // prefetch the column of the next transaction
    assign ram_raddr = accept ? n_col : r_col;

    blf_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata ({mid, pix}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table <= '0;
        end else if (i_cfg_we) begin
            r_table[{i_cfg_idx, {$clog2(TABLE_WORD_W){1'b0}}} +: TABLE_WORD_W] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row_len <= '0;
            r_row_cnt <= '0;
            r_win <= '0;
            r_bg <= 1'b0;
            r_lit <= '0;
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= accept && (n_col == r_col);
            if (accept) begin
                r_col <= n_col;
                r_row_len <= n_row_len;
                r_row_cnt <= n_row_cnt;
                r_win <= n_win;
                r_bg <= n_bg;
                r_lit <= i_pix.frame_end ? '0 : n_lit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= {mid, pix};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= emit;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_pix <= filt;
            r_out_row_end <= (r_col == '0);
            r_out_frame_end <= i_pix.frame_end;
            r_out_lit <= n_lit;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.filtered_pixel = r_out_pix;
    assign o_res.out_row_end = r_out_row_end;
    assign o_res.out_frame_end = r_out_frame_end;
    assign o_res.lit_total = r_out_lit;
endmodule

### sv/blf_checker.sv
// Port-level checks of the lookup-table filter, attached to the filter core by bind.
// Depends on blf_pkg and binary_3x3_lut_image_filter_core.
module blf_checker
    import blf_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_pix,
    input logic [LIT_W-1:0] i_out_lit
);
    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_lit)
            && $stable(i_out_pix))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // an empty output register never blocks the input
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    a_lit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_out_pix || i_out_lit != '0) && i_out_lit <= LIT_MAX)
        else $error("lit total inconsistent with pixel");
endmodule

bind binary_3x3_lut_image_filter_core blf_checker u_blf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_pix   (o_res.filtered_pixel),
    .i_out_lit   (o_res.lit_total)
);

### verif/testbench.sv
// Self-checking testbench of the binary 3x3 lookup-table image filter core.
// Depends on blf_pkg, blf_in_if, blf_out_if and the core; drives pixel frames through a
// bit-exact predictor of the filter and compares every filtered pixel in order.
module testbench;
    import blf_pkg::*;

    localparam int unsigned MAX_W = 256;
    localparam int unsigned MAX_H = 256;
    localparam int unsigned RANDOM_ITEMS = 280;
    localparam int unsigned RANDOM_PHASES = 4;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_PAD = 8;
    localparam int unsigned SETTLE_LIMIT = 4000;
    localparam int unsigned REPORT_LIMIT = 40;
    localparam int unsigned WIDE_EXTRA = 4;

    localparam logic [TABLE_BITS-1:0] CENTER_COPY = {TABLE_WORDS{64'hFFFF_0000_FFFF_0000}};
    localparam logic [TABLE_BITS-1:0] ALL_LIT = '1;
    localparam logic [TABLE_BITS-1:0] ALL_DARK = '0;

    localparam logic [20:0] UNCHECKED = 21'd0;
    localparam logic CHECKED = 1'b1;

    typedef struct packed {
        logic command;
        logic pixel_value;
        logic row_end;
        logic frame_end;
    } t_pix_item;

    typedef struct packed {
        logic             filtered_pixel;
        logic             out_row_end;
        logic             out_frame_end;
        logic [LIT_W-1:0] lit_total;
    } t_filt_res;

    typedef struct packed {
        t_pix_item item;
        logic      typed;
        t_filt_res res;
    } t_dir_row;

    typedef enum logic [1:0] {
        FRAME_CLEAN,
        FRAME_EXTRA_DRAIN,
        FRAME_EARLY_END,
        FRAME_NO_END
    } t_frame_kind;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [TABLE_WORD_W-1:0] i_cfg_data;

    blf_in_if  pix_if ();
    blf_out_if res_if ();

    binary_3x3_lut_image_filter_core #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_pix     (pix_if),
        .o_res     (res_if)
    );

    // predictor state
    logic [TABLE_BITS-1:0] lut;
    logic                  line_up [MAX_W];
    logic                  line_mid [MAX_W];
    t_window               win_q;
    int unsigned           col_q;
    int unsigned           row_len_q;
    int unsigned           row_q;
    logic                  bg_q;
    logic [LIT_W-1:0]      lit_q;

    t_filt_res   pending_pixels [$];
    t_dir_row    directed_rows [$];
    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned burst_left;
    bit          hold_off_req;
    logic        cur_typed;
    t_filt_res   cur_typed_res;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic note_failure(input string msg);
        mismatch_count++;
        // keep the log short on a badly broken build
        if (mismatch_count <= REPORT_LIMIT)
            $error("%s", msg);
    endtask

    task automatic add_row(input t_dir_row row);
        directed_rows = {directed_rows, row};
    endtask

    task automatic filter_predict(input t_pix_item it, output logic caused,
                                  output t_filt_res res);
        logic        b;
        logic        p;
        logic        up;
        logic        mid;
        t_window     newcol;
        t_window     w;
        int unsigned c;
        int unsigned r;
        b = bg_q;
        p = (it.command == CMD_DRAIN) ? b : it.pixel_value;
        c = (col_q >= MAX_W) ? 0 : col_q;
        r = row_q;
        up = (r >= 2) ? line_up[c] : b;
        mid = (r >= 1) ? line_mid[c] : b;
        line_up[c] = mid;
        line_mid[c] = p;
        newcol = {2'b00, up, 2'b00, mid, 2'b00, p};
        if (c == 0) begin
            // a new row: the window's right column is the background ring
            w = ((win_q << 1) & SLIDE_MASK) | (b ? BG_COLUMN : TABLE_IDX_FIRST);
            caused = (r >= 2);
            res.out_row_end = 1'b1;
            win_q = (b ? SLIDE_MASK : TABLE_IDX_FIRST) | newcol;
        end else begin
            win_q = ((win_q << 1) & SLIDE_MASK) | newcol;
            w = win_q;
            caused = (r >= 1);
            res.out_row_end = 1'b0;
        end
        res.filtered_pixel = lut[w];
        if (caused && lut[w] && lit_q < LIT_MAX)
            lit_q++;
        res.out_frame_end = it.frame_end;
        res.lit_total = lit_q;

        if (row_len_q == 0) begin
            if (it.row_end || c + 1 >= MAX_W) begin
                row_len_q = c + 1;
                col_q = 0;
                if (row_q < MAX_H + 1)
                    row_q++;
            end else begin
                col_q = c + 1;
            end
        end else if (c + 1 >= row_len_q) begin
            col_q = 0;
            if (row_q < MAX_H + 1)
                row_q++;
        end else begin
            col_q = c + 1;
        end

        if (it.frame_end) begin
            bg_q = b ? lut[TABLE_IDX_LAST] : lut[TABLE_IDX_FIRST];
            col_q = 0;
            row_q = 0;
            row_len_q = 0;
            lit_q = '0;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_filt_res seen;
        t_filt_res want;
        t_filt_res pred;
        t_pix_item it;
        logic      caused;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                seen = {res_if.filtered_pixel, res_if.out_row_end, res_if.out_frame_end,
                        res_if.lit_total};
                if (pending_pixels.size() == 0) begin
                    note_failure($sformatf("unexpected filtered pixel, lit_total %0d",
                                           seen.lit_total));
                end else begin
                    want = pending_pixels.pop_front();
                    if (seen.filtered_pixel !== want.filtered_pixel)
                        note_failure($sformatf("filtered_pixel: expected %0d, got %0d",
                                               want.filtered_pixel, seen.filtered_pixel));
                    if (seen.out_row_end !== want.out_row_end)
                        note_failure($sformatf("out_row_end: expected %0d, got %0d",
                                               want.out_row_end, seen.out_row_end));
                    if (seen.out_frame_end !== want.out_frame_end)
                        note_failure($sformatf("out_frame_end: expected %0d, got %0d",
                                               want.out_frame_end, seen.out_frame_end));
                    if (seen.lit_total !== want.lit_total)
                        note_failure($sformatf("lit_total: expected %0d, got %0d",
                                               want.lit_total, seen.lit_total));
                end
            end
            if (pix_if.valid && pix_if.ready) begin
                it = {pix_if.command, pix_if.pixel_value, pix_if.row_end, pix_if.frame_end};
                filter_predict(it, caused, pred);
                if (caused)
                    pending_pixels = {pending_pixels, (cur_typed ? cur_typed_res : pred)};
            end
        end
    end

    // receiver: random ready pattern, plus one long hold-off on request
    initial begin : receiver
        int unsigned stall;
        res_if.ready <= 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            repeat (($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12))
                @(negedge i_clk);
            stall = $urandom_range(0, 4);
            if (stall != 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
        end
    end

    task automatic send_item(input t_pix_item it, input logic typed, input t_filt_res exp_res);
        @(negedge i_clk);
        if (burst_left == 0) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
        pix_if.valid <= 1'b1;
        pix_if.command <= it.command;
        pix_if.pixel_value <= it.pixel_value;
        pix_if.row_end <= it.row_end;
        pix_if.frame_end <= it.frame_end;
        cur_typed = typed;
        cur_typed_res = exp_res;
        burst_left--;
        items_sent++;
        do @(posedge i_clk); while (!pix_if.ready);
    endtask

    // drop valid and hold until every predicted pixel has come out or the settle limit runs out
    task automatic quiesce;
        int unsigned waited;
        waited = 0;
        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        while (pending_pixels.size() != 0 && waited < SETTLE_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (DRAIN_PAD) @(negedge i_clk);
    endtask

    task automatic load_table(input logic [TABLE_BITS-1:0] bits);
        int unsigned k;
        for (k = 0; k < TABLE_WORDS; k++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= CFG_IDX_W'(k);
            i_cfg_data <= bits[k*TABLE_WORD_W +: TABLE_WORD_W];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        lut = bits;
    endtask

    task automatic send_frame(input int unsigned width, input int unsigned height,
                              input t_frame_kind kind, input logic mark_row_end,
                              input bit pause_mid);
        int unsigned body;
        int unsigned last;
        int unsigned stop;
        int unsigned n;
        t_pix_item   it;
        body = width * height;
        last = body + width;
        if (kind == FRAME_EXTRA_DRAIN)
            last += width * $urandom_range(1, 3);
        stop = (kind == FRAME_EARLY_END) ? $urandom_range(0, last) : last;
        for (n = 0; n <= stop; n++) begin
            if (pause_mid && n == body / 2)
                quiesce();
            it.pixel_value = 1'($urandom_range(0, 1));
            if (n < body) begin
                it.command = ($urandom_range(0, 11) == 0) ? CMD_DRAIN : CMD_PIXEL;
                // row_end only counts in the first row; later rows get noise
                it.row_end = (n < width) ? (mark_row_end && n == width - 1)
                                         : 1'($urandom_range(0, 1));
            end else begin
                it.command = CMD_DRAIN;
                it.row_end = 1'($urandom_range(0, 1));
            end
            it.frame_end = (n == stop) && (kind != FRAME_NO_END);
            send_item(it, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        int unsigned           phase;
        int unsigned           goal;
        int unsigned           width;
        int unsigned           height;
        int unsigned           pick;
        int unsigned           j;
        int unsigned           n;
        logic [TABLE_BITS-1:0] tbl;
        t_frame_kind           kind;
        bit                    pause_pending;
        t_pix_item             noise;

        mismatch_count = 0;
        items_sent = 0;
        burst_left = 0;
        hold_off_req = 1'b0;
        cur_typed = 1'b0;
        cur_typed_res = '0;
        lut = '0;
        win_q = '0;
        col_q = 0;
        row_len_q = 0;
        row_q = 0;
        bg_q = 1'b0;
        lit_q = '0;
        for (j = 0; j < MAX_W; j++) begin
            line_up[j] = 1'b0;
            line_mid[j] = 1'b0;
        end

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        pix_if.valid <= 1'b0;
        pix_if.command <= CMD_PIXEL;
        pix_if.pixel_value <= 1'b0;
        pix_if.row_end <= 1'b0;
        pix_if.frame_end <= 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames with a table that copies the center pixel.
        // 3x3 frame: rows 101 / 010 / 111, then four drains.
        add_row({CMD_PIXEL, 1'b1, 1'b0, 1'b0, UNCHECKED});
        add_row({CMD_PIXEL, 1'b0, 1'b0, 1'b0, UNCHECKED});
        add_row({CMD_PIXEL, 1'b1, 1'b1, 1'b0, UNCHECKED});
        add_row({CMD_PIXEL, 1'b0, 1'b0, 1'b0, UNCHECKED});
        add_row({CMD_PIXEL, 1'b1, 1'b0, 1'b0, CHECKED, 1'b1, 1'b0, 1'b0, 17'd1});
        add_row({CMD_PIXEL, 1'b0, 1'b0, 1'b0, CHECKED, 1'b0, 1'b0, 1'b0, 17'd1});
        add_row({CMD_PIXEL, 1'b1, 1'b0, 1'b0, CHECKED, 1'b1, 1'b1, 1'b0, 17'd2});
        add_row({CMD_PIXEL, 1'b1, 1'b0, 1'b0, CHECKED, 1'b0, 1'b0, 1'b0, 17'd2});
        add_row({CMD_PIXEL, 1'b1, 1'b0, 1'b0, CHECKED, 1'b1, 1'b0, 1'b0, 17'd3});
        add_row({CMD_DRAIN, 1'b1, 1'b0, 1'b0, CHECKED, 1'b0, 1'b1, 1'b0, 17'd3});
        add_row({CMD_DRAIN, 1'b0, 1'b0, 1'b0, CHECKED, 1'b1, 1'b0, 1'b0, 17'd4});
        add_row({CMD_DRAIN, 1'b1, 1'b1, 1'b0, CHECKED, 1'b1, 1'b0, 1'b0, 17'd5});
        add_row({CMD_DRAIN, 1'b0, 1'b0, 1'b1, CHECKED, 1'b1, 1'b1, 1'b1, 17'd6});
        // drains inside the first row, ignored row_end later, early frame end on a pixel
        add_row({CMD_PIXEL, 1'b1, 1'b0, 1'b0, UNCHECKED});
        add_row({CMD_DRAIN, 1'b1, 1'b0, 1'b0, UNCHECKED});
        add_row({CMD_DRAIN, 1'b0, 1'b1, 1'b0, UNCHECKED});
        add_row({CMD_PIXEL, 1'b1, 1'b0, 1'b0, UNCHECKED});
        add_row({CMD_PIXEL, 1'b1, 1'b1, 1'b0, CHECKED, 1'b1, 1'b0, 1'b0, 17'd1});
        add_row({CMD_PIXEL, 1'b1, 1'b0, 1'b0, UNCHECKED});
        add_row({CMD_PIXEL, 1'b0, 1'b0, 1'b0, UNCHECKED});
        add_row({CMD_PIXEL, 1'b1, 1'b0, 1'b1, CHECKED, 1'b1, 1'b0, 1'b1, 17'd2});
        // frame end on the very first item: no result
        add_row({CMD_DRAIN, 1'b1, 1'b1, 1'b1, UNCHECKED});

        load_table(CENTER_COPY);
        for (j = 0; j < directed_rows.size(); j++)
            send_item(directed_rows[j].item, directed_rows[j].typed, directed_rows[j].res);
        quiesce();

        pause_pending = 1'b1;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            for (j = 0; j < TABLE_BITS / 32; j++)
                tbl[j*32 +: 32] = $urandom;
            case (phase)
                1: tbl = ALL_LIT;
                2: tbl = ALL_DARK;
                3: begin
                    // background toggles at every frame end
                    tbl[TABLE_IDX_FIRST] = 1'b1;
                    tbl[TABLE_IDX_LAST] = 1'b0;
                end
                default: ;
            endcase
            load_table(tbl);
            if (phase == 0)
                hold_off_req = 1'b1;
            goal = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_sent < goal) begin
                pick = $urandom_range(0, 19);
                if (pick < 2) begin
                    for (n = $urandom_range(1, 12); n > 0; n--) begin
                        noise = 4'($urandom_range(0, 15));
                        noise.frame_end = ($urandom_range(0, 15) == 0);
                        send_item(noise, 1'b0, '0);
                    end
                end else begin
                    if ($urandom_range(0, 9) == 0)
                        width = $urandom_range(1, 2);
                    else if ($urandom_range(0, 14) == 0)
                        width = $urandom_range(13, 40);
                    else
                        width = $urandom_range(3, 10);
                    height = $urandom_range(1, 8);
                    if (pick < 14)
                        kind = FRAME_CLEAN;
                    else if (pick < 16)
                        kind = FRAME_EXTRA_DRAIN;
                    else if (pick < 18)
                        kind = FRAME_EARLY_END;
                    else
                        kind = FRAME_NO_END;
                    send_frame(width, height, kind, 1'b1, pause_pending);
                    pause_pending = 1'b0;
                end
            end
            quiesce();
        end

        // A first row that never marks its end is cut at the width limit; the frame ends
        // a few pixels into the next row.
        load_table(CENTER_COPY);
        send_item({CMD_DRAIN, 1'b0, 1'b0, 1'b1}, 1'b0, '0);
        for (n = 0; n < MAX_W + WIDE_EXTRA; n++) begin
            noise.command = CMD_PIXEL;
            noise.pixel_value = 1'($urandom_range(0, 1));
            noise.row_end = 1'b0;
            noise.frame_end = (n == MAX_W + WIDE_EXTRA - 1);
            send_item(noise, 1'b0, '0);
        end
        // One-pixel rows run past the row limit.
        send_frame(1, MAX_H + 2, FRAME_CLEAN, 1'b1, 1'b0);
        quiesce();

        if (pending_pixels.size() != 0)
            note_failure($sformatf("%0d filtered pixels never arrived", pending_pixels.size()));
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
